>>> src/polynomial_syntax_checker_defines.svh
// Assertion macros shared by the checker of the polynomial syntax checker.
`ifndef POLYNOMIAL_SYNTAX_CHECKER_DEFINES_SVH
`define POLYNOMIAL_SYNTAX_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PSC_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("polynomial syntax checker: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PSC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("polynomial syntax checker: next-cycle check failed");

// Next-cycle implication that stays live while reset is high.
`define PSC_ASSERT_RESET(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("polynomial syntax checker: reset check failed");

`endif

>>> src/psc_pkg.sv
// Shared types and codes of the polynomial syntax checker.
package psc_pkg;

   // character classes handed from the front end to the parser
   localparam logic [2:0] CLS_OTHER   = 3'd0;
   localparam logic [2:0] CLS_SPACE   = 3'd1;
   localparam logic [2:0] CLS_SEMI    = 3'd2;
   localparam logic [2:0] CLS_SIGN    = 3'd3;
   localparam logic [2:0] CLS_ZERO    = 3'd4;
   localparam logic [2:0] CLS_NZDIGIT = 3'd5;
   localparam logic [2:0] CLS_X       = 3'd6;
   localparam logic [2:0] CLS_CARET   = 3'd7;

   typedef logic [2:0] class_type;

   typedef struct packed {
      class_type char_class;
      logic      last;
   } entry_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   typedef logic [3:0] status_type;

   localparam status_type ST_OK         = 4'd0;
   localparam status_type ST_EMPTY      = 4'd1;
   localparam status_type ST_NO_COEF    = 4'd2;
   localparam status_type ST_NO_X       = 4'd3;
   localparam status_type ST_NO_CARET   = 4'd4;
   localparam status_type ST_NO_EXP     = 4'd5;
   localparam status_type ST_DBL_SIGN   = 4'd6;
   localparam status_type ST_TRAIL_SIGN = 4'd7;
   localparam status_type ST_LEAD_ZERO  = 4'd8;

endpackage

>>> src/psc_front.sv
// Front end: takes input transactions and classifies each character.
module psc_front (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] character
   input  logic                req_tlast,   // last_char
   input  logic                queue_full,
   output logic                push,
   output psc_pkg::entry_type  push_entry
);
   import psc_pkg::*;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_CARET = 8'h5E;

   class_type cls;

   always_comb begin
      if (req_tdata == CH_SPACE) cls = CLS_SPACE;
      else if (req_tdata == CH_SEMI) cls = CLS_SEMI;
      else if (req_tdata == CH_PLUS || req_tdata == CH_MINUS) cls = CLS_SIGN;
      else if (req_tdata == CH_ZERO) cls = CLS_ZERO;
      else if (req_tdata >= CH_ONE && req_tdata <= CH_NINE) cls = CLS_NZDIGIT;
      else if (req_tdata == CH_X) cls = CLS_X;
      else if (req_tdata == CH_CARET) cls = CLS_CARET;
      else cls = CLS_OTHER;
   end

   assign req_tready            = !queue_full;
   assign push                  = req_tvalid && !queue_full;
   assign push_entry.char_class = cls;
   assign push_entry.last       = req_tlast;

endmodule

>>> src/psc_queue.sv
// Short queue of classified characters between front end and parser.
module psc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psc_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output psc_pkg::entry_type  pop_entry
);
   import psc_pkg::*;

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   localparam logic [PTR_W:0] DEPTH_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   assign full      = (count_ff == DEPTH_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

>>> src/psc_back.sv
// Parser: walks the grammar over classified characters and holds the result.
module psc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  psc_pkg::entry_type  pop_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata    // [3:0] status, [4] is_valid, [7:5] zero
);
   import psc_pkg::*;

   localparam logic [2:0] PH_START     = 3'd0;
   localparam logic [2:0] PH_LEAD_SIGN = 3'd1;
   localparam logic [2:0] PH_COEF      = 3'd2;
   localparam logic [2:0] PH_AFTER_X   = 3'd3;
   localparam logic [2:0] PH_CARET     = 3'd4;
   localparam logic [2:0] PH_EXP_SIGN  = 3'd5;
   localparam logic [2:0] PH_EXP       = 3'd6;
   localparam logic [2:0] PH_TERM_SIGN = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   status_type  err_ff, err_in;
   logic        seen_ff, seen_in;
   logic        ended_ff, ended_in;
   logic        out_valid_ff, out_valid_in;
   status_type  out_status_ff, out_status_in;

   logic        active;
   logic [2:0]  phase_mid;
   status_type  err_mid;
   logic        seen_mid;
   logic        ended_mid;
   logic [2:0]  coef_phase;
   status_type  coef_err;
   status_type  end_st;
   class_type   cls;

   assign cls    = pop_entry.char_class;
   assign active = !ended_ff && (err_ff == ST_OK);
   assign pop    = not_empty && (!out_valid_ff || rsp_tready);

   // start of a coefficient: must be a non-zero digit
   always_comb begin
      coef_phase = phase_ff;
      coef_err   = ST_OK;
      if (cls == CLS_NZDIGIT) coef_phase = PH_COEF;
      else if (cls == CLS_ZERO) coef_err = ST_LEAD_ZERO;
      else coef_err = ST_NO_COEF;
   end

   // character step; end-of-text status is taken from the updated phase
   always_comb begin
      phase_mid = phase_ff;
      err_mid   = err_ff;
      seen_mid  = seen_ff;
      ended_mid = ended_ff;
      if (active && cls != CLS_SEMI && cls != CLS_SPACE) begin
         seen_mid = 1'b1;
         unique case (phase_ff)
            PH_LEAD_SIGN: begin
               phase_mid = coef_phase;
               err_mid   = coef_err;
            end
            PH_COEF: begin
               if (cls == CLS_X) phase_mid = PH_AFTER_X;
               else if (cls != CLS_ZERO && cls != CLS_NZDIGIT) err_mid = ST_NO_X;
            end
            PH_AFTER_X: begin
               if (cls == CLS_CARET) phase_mid = PH_CARET;
               else err_mid = ST_NO_CARET;
            end
            PH_CARET: begin
               if (cls == CLS_SIGN) phase_mid = PH_EXP_SIGN;
               else if (cls == CLS_ZERO || cls == CLS_NZDIGIT) phase_mid = PH_EXP;
               else err_mid = ST_NO_EXP;
            end
            PH_EXP_SIGN: begin
               if (cls == CLS_ZERO || cls == CLS_NZDIGIT) phase_mid = PH_EXP;
               else err_mid = ST_NO_EXP;
            end
            PH_EXP: begin
               if (cls == CLS_SIGN) phase_mid = PH_TERM_SIGN;
               else if (cls != CLS_ZERO && cls != CLS_NZDIGIT) begin
                  phase_mid = coef_phase;
                  err_mid   = coef_err;
               end
            end
            PH_TERM_SIGN: begin
               if (cls == CLS_SIGN) err_mid = ST_DBL_SIGN;
               else begin
                  phase_mid = coef_phase;
                  err_mid   = coef_err;
               end
            end
            default: begin
               if (cls == CLS_SIGN) phase_mid = PH_LEAD_SIGN;
               else begin
                  phase_mid = coef_phase;
                  err_mid   = coef_err;
               end
            end
         endcase
      end
      if (active && cls == CLS_SEMI) begin
         err_mid   = end_st;
         ended_mid = 1'b1;
      end
   end

   // status if the text ends here; a ';' ends it before the character is fed
   always_comb begin
      if (!seen_ff && !(active && cls != CLS_SEMI && cls != CLS_SPACE
                        && !(cls == CLS_SEMI))) begin
         end_st = ST_EMPTY;
      end else begin
         case ((cls == CLS_SEMI) ? phase_ff : phase_mid)
            PH_EXP:       end_st = ST_OK;
            PH_COEF:      end_st = ST_NO_X;
            PH_AFTER_X:   end_st = ST_NO_CARET;
            PH_CARET,
            PH_EXP_SIGN:  end_st = ST_NO_EXP;
            PH_TERM_SIGN: end_st = ST_TRAIL_SIGN;
            PH_LEAD_SIGN: end_st = ST_NO_COEF;
            default:      end_st = ST_EMPTY;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_mid;
      err_in        = err_mid;
      seen_in       = seen_mid;
      ended_in      = ended_mid;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      if (!pop) begin
         phase_in = phase_ff;
         err_in   = err_ff;
         seen_in  = seen_ff;
         ended_in = ended_ff;
      end else if (pop_entry.last) begin
         out_valid_in  = 1'b1;
         out_status_in = (!ended_mid && err_mid == ST_OK) ? end_st : err_mid;
         phase_in      = PH_START;
         err_in        = ST_OK;
         seen_in       = 1'b0;
         ended_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         err_ff       <= ST_OK;
         seen_ff      <= 1'b0;
         ended_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         seen_ff      <= seen_in;
         ended_ff     <= ended_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, (out_status_ff == ST_OK), out_status_ff};

endmodule

>>> src/polynomial_syntax_checker.sv
// Top level of the polynomial syntax checker.
// Checks a character stream against [sign] coef x^ [sign] exp {(+|-) coef x^ [sign] exp},
// one character per req transaction, and gives one status on rsp when the character
// flagged by req_tlast has been taken. A character is accepted every cycle while the
// four-entry queue between the classifier and the parser has room; the parser retires
// one queued character per cycle unless the result register still holds an untaken
// status. The status is registered: the last character is classified and queued when it is
// accepted, and parsed into the result register once it reaches the head of the queue.
module polynomial_syntax_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] character
   input  logic       req_tlast,    // last_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [3:0] status, [4] is_valid, [7:5] zero
);
   import psc_pkg::*;

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      not_empty;
   entry_type pop_entry;

   psc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   psc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   psc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> src/psc_checker.sv
// Port-level assertions for the polynomial syntax checker, bound to the top level.
`include "polynomial_syntax_checker_defines.svh"

module psc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import psc_pkg::*;

   `PSC_ASSERT_NEXT(a_req_hold, req_tvalid && !req_tready, req_tvalid && $stable(req_tdata) && $stable(req_tlast))
   `PSC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `PSC_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `PSC_ASSERT_NOW(a_valid_flag, rsp_tvalid, rsp_tdata[4] == (rsp_tdata[3:0] == ST_OK))
   `PSC_ASSERT_RESET(a_reset_quiet, reset, !rsp_tvalid)

endmodule

bind polynomial_syntax_checker psc_checker u_psc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
